FILE: hdl/vslp_pkg.sv
`timescale 1ns / 1ps

package vslp_pkg;

  localparam int unsigned LINE_BYTES = 41;
  localparam int unsigned LINE_BITS  = LINE_BYTES * 8;
  localparam int unsigned SLOT_TABLE = 14;
  localparam int unsigned CODE_W     = 64;
  localparam int unsigned VALUE_W    = 48;
  localparam int unsigned SLOT_W     = 4;
  localparam int unsigned CNT_W      = 6;

  localparam logic [1:0] OP_CLEAR   = 2'd0;
  localparam logic [1:0] OP_INSERT  = 2'd1;
  localparam logic [1:0] OP_EXTRACT = 2'd2;
  localparam logic [1:0] OP_EMIT    = 2'd3;

  localparam int unsigned SLOT_WIDTH [SLOT_TABLE] = '{
    23, 20, 21, 15, 28, 28, 31, 29, 26, 24, 20, 20, 20, 23
  };

  localparam int unsigned SLOT_OFFSET [SLOT_TABLE] = '{
    0, 23, 43, 64, 79, 107, 135, 166, 195, 221, 245, 265, 285, 305
  };

  typedef logic [LINE_BITS-1:0] line_t;

  typedef struct packed {
    logic clear;
    logic insert;
    logic capture;
    logic load_extract;
    logic load_byte;
    logic cnt_clear;
    logic cnt_inc;
  } cmd_t;

  typedef struct packed {
    logic last_byte;
  } status_t;

  function automatic logic [CODE_W-1:0] width_mask(int unsigned s);
    return (CODE_W'(1) << SLOT_WIDTH[s]) - CODE_W'(1);
  endfunction

  // field bits that are overwritten; the field's last byte is merged instead
  function automatic line_t clear_mask(int unsigned s);
    int unsigned last_start;
    line_t       hi;
    line_t       lo;
    last_start = ((SLOT_OFFSET[s] + SLOT_WIDTH[s] - 1) >> 3) << 3;
    hi = (line_t'(1) << last_start) - line_t'(1);
    lo = (line_t'(1) << SLOT_OFFSET[s]) - line_t'(1);
    return hi & ~lo;
  endfunction

endpackage

FILE: hdl/vslp_in_if.sv
`timescale 1ns / 1ps

interface vslp_in_if;
  import vslp_pkg::*;

  logic              valid;
  logic              ready;
  logic [1:0]        opcode;
  logic [SLOT_W-1:0] slot_index;
  logic [CODE_W-1:0] insert_code;

  modport source (output valid, output opcode, output slot_index, output insert_code,
                  input ready);
  modport sink (input valid, input opcode, input slot_index, input insert_code,
                output ready);
endinterface

FILE: hdl/vslp_out_if.sv
`timescale 1ns / 1ps

interface vslp_out_if;
  import vslp_pkg::*;

  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] out_value;
  logic               out_last;

  modport source (output valid, output out_value, output out_last, input ready);
  modport sink (input valid, input out_value, input out_last, output ready);
endinterface

FILE: hdl/vslp_ctrl.sv
`timescale 1ns / 1ps

module vslp_ctrl
  import vslp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic [1:0] opcode,
  output logic       in_ready,
  input  logic       out_ready,
  output logic       out_valid,
  input  status_t    status,
  output cmd_t       cmd
);

  localparam logic [1:0] S_IDLE    = 2'd0;
  localparam logic [1:0] S_EXTRACT = 2'd1;
  localparam logic [1:0] S_EMIT    = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       out_valid_next;
  logic       out_free;
  logic       accept;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    cmd        = '0;
    if (accept) begin
      cmd.capture = 1'b1;
      unique case (opcode)
        OP_CLEAR:   cmd.clear = 1'b1;
        OP_INSERT:  cmd.insert = 1'b1;
        OP_EXTRACT: state_next = S_EXTRACT;
        OP_EMIT: begin
          cmd.cnt_clear = 1'b1;
          state_next    = S_EMIT;
        end
        default: ;
      endcase
    end
    if (state == S_EXTRACT && out_free) begin
      cmd.load_extract = 1'b1;
      state_next       = S_IDLE;
    end
    if (state == S_EMIT && out_free) begin
      cmd.load_byte = 1'b1;
      if (status.last_byte) begin
        state_next = S_IDLE;
      end else begin
        cmd.cnt_inc = 1'b1;
      end
    end
  end

  always_comb begin
    out_valid_next = out_valid;
    if (cmd.load_extract || cmd.load_byte) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

FILE: hdl/vslp_datapath.sv
`timescale 1ns / 1ps

module vslp_datapath
  import vslp_pkg::*;
#(
  parameter int unsigned NUM_SLOTS = 14,
  parameter int unsigned TAG_SHIFT = 44
) (
  input  logic               clk,
  input  logic               rst,
  input  cmd_t               cmd,
  output status_t            status,
  input  logic [SLOT_W-1:0]  slot_index,
  input  logic [CODE_W-1:0]  insert_code,
  output logic [VALUE_W-1:0] out_value,
  output logic               out_last
);

  line_t              line;
  logic [SLOT_W-1:0]  slot_q;
  logic [CNT_W-1:0]   cnt;
  line_t              ins_bits;
  line_t              ins_clr;
  logic               ins_ok;
  logic               ext_ok;
  logic [CODE_W-1:0]  ext_field;
  logic [VALUE_W-1:0] ext_tag;
  logic [VALUE_W-1:0] ext_value;
  logic [7:0]         emit_byte;

  assign ins_ok = (32'(slot_index) < NUM_SLOTS) && (32'(slot_index) < SLOT_TABLE);
  assign ext_ok = (32'(slot_q) < NUM_SLOTS) && (32'(slot_q) < SLOT_TABLE);

  always_comb begin
    ins_bits = '0;
    ins_clr  = '0;
    for (int s = 0; s < SLOT_TABLE; s++) begin
      if (slot_index == SLOT_W'(s)) begin
        ins_bits = line_t'(insert_code & width_mask(s)) << SLOT_OFFSET[s];
        ins_clr  = clear_mask(s);
      end
    end
  end

  always_comb begin
    ext_field = '0;
    for (int s = 0; s < SLOT_TABLE; s++) begin
      if (slot_q == SLOT_W'(s)) begin
        ext_field = CODE_W'(line >> SLOT_OFFSET[s]) & width_mask(s);
      end
    end
    if (!ext_ok) begin
      ext_field = '0;
    end
    ext_tag   = VALUE_W'(CODE_W'(slot_q) << TAG_SHIFT);
    ext_value = (ext_field != '0) ? (VALUE_W'(ext_field) | ext_tag) : '0;
  end

  assign emit_byte        = line[{cnt, 3'b000} +: 8];
  assign status.last_byte = (cnt == CNT_W'(LINE_BYTES - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      line <= '0;
      cnt  <= '0;
    end else begin
      if (cmd.clear) begin
        line <= '0;
      end else if (cmd.insert && ins_ok) begin
        line <= (line & ~ins_clr) | ins_bits;
      end
      if (cmd.cnt_clear) begin
        cnt <= '0;
      end else if (cmd.cnt_inc) begin
        cnt <= cnt + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      slot_q <= slot_index;
    end
    if (cmd.load_extract) begin
      out_value <= ext_value;
      out_last  <= 1'b1;
    end else if (cmd.load_byte) begin
      out_value <= VALUE_W'(emit_byte);
      out_last  <= status.last_byte;
    end
  end

endmodule

FILE: hdl/vliw_slot_line_packer_unit.sv
`timescale 1ns / 1ps
// vliw_slot_line_packer_unit
// keeps one 41-byte instruction line built from 14 issue-slot fields
// req channel (valid/ready): opcode, slot_index, insert_code
//   clear and insert update the line at the transfer and give no result
//   extract gives one result: nonzero slot code tagged at TAG_SHIFT, out_last set
//   emit gives 41 results, line bytes 0 to 40, out_last set on the final byte
// rsp channel (valid/ready): out_value, out_last from an output register
// extract: the controller enters its extract state at the transfer and loads the
//   result into the output register once it is free; emit loads bytes from the
//   emit state, one byte per cycle while rsp is taken, via the byte counter
// clear and insert leave req ready; extract and emit hold req off until done
// req is ready whenever no extract or emit is in progress, also while a result
//   waits in the output register; a stalled receiver holds the controller in its
//   extract or emit state until the output register is free
// reset clears the line to zero, drops rsp valid and returns to idle
module vliw_slot_line_packer_unit
  import vslp_pkg::*;
#(
  parameter int unsigned NUM_SLOTS = 14,
  parameter int unsigned TAG_SHIFT = 44
) (
  input  logic       clk,
  input  logic       rst,
  vslp_in_if.sink    req,
  vslp_out_if.source rsp
);

  cmd_t    cmd;
  status_t status;

  vslp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .opcode    (req.opcode),
    .in_ready  (req.ready),
    .out_ready (rsp.ready),
    .out_valid (rsp.valid),
    .status    (status),
    .cmd       (cmd)
  );

  vslp_datapath #(
    .NUM_SLOTS (NUM_SLOTS),
    .TAG_SHIFT (TAG_SHIFT)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .slot_index  (req.slot_index),
    .insert_code (req.insert_code),
    .out_value   (rsp.out_value),
    .out_last    (rsp.out_last)
  );

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && !rsp.ready) |-> !(cmd.load_extract || cmd.load_byte))
    else $error("output register loaded while holding an untaken result");

  a_busy_no_accept: assert property (@(posedge clk) disable iff (rst)
    (cmd.load_extract || cmd.load_byte) |-> !req.ready)
    else $error("request ready while a result is being produced");

  a_extract_busy: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready && req.opcode == OP_EXTRACT) |=> !req.ready)
    else $error("extract did not hold off the next request");

  a_emit_last: assert property (@(posedge clk) disable iff (rst)
    (cmd.load_byte && status.last_byte) |=> (rsp.valid && rsp.out_last))
    else $error("final emitted byte not marked last");

endmodule
